### hdl/tet_fast_squared_aspect_ratio_macros.svh
// Assertion helpers for the quality block.
`ifndef TET_FAST_SQUARED_ASPECT_RATIO_MACROS_SVH
`define TET_FAST_SQUARED_ASPECT_RATIO_MACROS_SVH

`ifndef SYNTHESIS
`define TFSAR_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfsar check failed");
`define TFSAR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfsar check failed");
`else
`define TFSAR_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define TFSAR_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

### hdl/tfsar_pkg.sv
`timescale 1ns / 1ps
package tfsar_pkg;

    localparam int FIELD_W        = 16;
    localparam int MAX_COORD_BITS = 24;
    localparam int Q_BITS         = 32;
    localparam int DIGIT_W        = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] az;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] cz;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
        logic signed [FIELD_W-1:0] dz;
    } in_item_t;

    typedef struct packed {
        logic [Q_BITS-1:0] quality;
        logic              inverted;
    } out_item_t;

endpackage

### hdl/tfsar_mul.sv
`timescale 1ns / 1ps
// Two-stage multiplier: B split into digits, partial products, then sum.
module tfsar_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic [AW+BW-1:0]   p
);

    localparam int DG  = tfsar_pkg::DIGIT_W;
    localparam int NCH = (BW + DG - 1) / DG;
    localparam int BPW = NCH * DG;

    logic [BPW-1:0]      bx;
    logic [AW+DG-1:0]    pp_reg [NCH];
    logic [AW+BW-1:0]    p_reg;
    logic [AW+BW-1:0]    p_next;

    assign bx = BPW'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NCH; k++) begin
                pp_reg[k] <= (AW+DG)'(a) * (AW+DG)'(bx[k*DG +: DG]);
            end
            p_reg <= p_next;
        end
    end

    always_comb begin
        logic [AW+BPW-1:0] acc;
        acc = '0;
        for (int k = 0; k < NCH; k++) begin
            acc = acc + ((AW+BPW)'(pp_reg[k]) << (k*DG));
        end
        p_next = acc[AW+BW-1:0];
    end

    assign p = p_reg;

endmodule

### hdl/tfsar_front.sv
`timescale 1ns / 1ps
// Edges, face normals, signed volume and longest edge.
module tfsar_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tfsar_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [12*(2*COORD_BITS+2)+(3*COORD_BITS+3)+(2*COORD_BITS+2):0] out_data
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int NW  = 2*C + 2;
    localparam int LW  = 2*C + 2;
    localparam int PW  = 3*C + 1;
    localparam int VW  = 3*C + 4;
    localparam int VMW = VW - 1;
    localparam int FW  = tfsar_pkg::FIELD_W;
    localparam int XW  = tfsar_pkg::MAX_COORD_BITS;
    localparam int XU [4] = '{1, 2, 0, 3};
    localparam int XV [4] = '{2, 0, 1, 4};

    logic                 en;
    logic [4:0]           vld_reg;
    logic [FW-1:0]        fld [12];
    logic signed [DW-1:0] crd [4][3];

    logic signed [DW-1:0] e_reg [6][3];
    logic signed [NW-1:0] n_reg [4][3];
    logic signed [NW-1:0] n_c_reg [4][3];
    logic signed [NW-1:0] n_d_reg [4][3];
    logic signed [NW-1:0] n_e_reg [4][3];
    logic [LW-1:0]        len_reg [6];
    logic [LW-1:0]        lmax_c_reg [3];
    logic [LW-1:0]        lmax_d_reg;
    logic [LW-1:0]        l_e_reg;
    logic [C-1:0]         dmag_reg [3];
    logic                 dsg_reg [3];
    logic                 sg_c_reg [3];
    logic                 sg_d_reg [3];
    logic [NW-2:0]        nmag [3];
    logic [PW-1:0]        vp [3];
    logic [VMW-1:0]       vabs_reg;
    logic                 inv_reg;
    logic signed [VW-1:0] vsum;

    function automatic logic signed [NW-1:0] xdiff(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] c,
        input logic signed [DW-1:0] d
    );
        logic signed [NW-1:0] p;
        logic signed [NW-1:0] q;
        begin
            p = a * b;
            q = c * d;
            return p - q;
        end
    endfunction

    function automatic logic [LW-1:0] sq3(
        input logic signed [DW-1:0] x,
        input logic signed [DW-1:0] y,
        input logic signed [DW-1:0] z
    );
        logic signed [NW-1:0] px;
        logic signed [NW-1:0] py;
        logic signed [NW-1:0] pz;
        begin
            px = x * x;
            py = y * y;
            pz = z * z;
            return LW'(px) + LW'(py) + LW'(pz);
        end
    endfunction

    assign en        = !vld_reg[4] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[4];

    always_comb begin
        logic [XW-1:0] ext;
        fld[0]  = in_item.ax;
        fld[1]  = in_item.ay;
        fld[2]  = in_item.az;
        fld[3]  = in_item.bx;
        fld[4]  = in_item.by;
        fld[5]  = in_item.bz;
        fld[6]  = in_item.cx;
        fld[7]  = in_item.cy;
        fld[8]  = in_item.cz;
        fld[9]  = in_item.dx;
        fld[10] = in_item.dy;
        fld[11] = in_item.dz;
        for (int i = 0; i < 12; i++) begin
            ext = {{(XW-FW){1'b0}}, fld[i]};
            crd[i/3][i%3] = $signed({ext[C-1], ext[C-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // stage A: edge vectors ab, ac, ad, bc, cd, db
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                e_reg[0][c] <= crd[1][c] - crd[0][c];
                e_reg[1][c] <= crd[2][c] - crd[0][c];
                e_reg[2][c] <= crd[3][c] - crd[0][c];
                e_reg[3][c] <= crd[2][c] - crd[1][c];
                e_reg[4][c] <= crd[3][c] - crd[2][c];
                e_reg[5][c] <= crd[1][c] - crd[3][c];
            end
        end
    end

    // stage B: normals, squared lengths
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int f = 0; f < 4; f++) begin
                n_reg[f][0] <= xdiff(e_reg[XU[f]][1], e_reg[XV[f]][2],
                                     e_reg[XU[f]][2], e_reg[XV[f]][1]);
                n_reg[f][1] <= xdiff(e_reg[XU[f]][2], e_reg[XV[f]][0],
                                     e_reg[XU[f]][0], e_reg[XV[f]][2]);
                n_reg[f][2] <= xdiff(e_reg[XU[f]][0], e_reg[XV[f]][1],
                                     e_reg[XU[f]][1], e_reg[XV[f]][0]);
            end
            for (int k = 0; k < 6; k++) begin
                len_reg[k] <= sq3(e_reg[k][0], e_reg[k][1], e_reg[k][2]);
            end
            for (int k = 0; k < 3; k++) begin
                dsg_reg[k]  <= e_reg[k][0][DW-1];
                dmag_reg[k] <= e_reg[k][0][DW-1] ? C'(-e_reg[k][0]) : e_reg[k][0][C-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nmag[k] = n_reg[k][0][NW-1] ? (NW-1)'(-n_reg[k][0]) : n_reg[k][0][NW-2:0];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_vol
        tfsar_mul #(.AW(C), .BW(NW-1)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (dmag_reg[k]),
            .b    (nmag[k]),
            .p    (vp[k])
        );
    end

    // stages C, D: product pipeline, maximum of the edge lengths
    always_ff @(posedge aclk) begin
        if (en) begin
            n_c_reg <= n_reg;
            n_d_reg <= n_c_reg;
            for (int k = 0; k < 3; k++) begin
                sg_c_reg[k]   <= dsg_reg[k] ^ n_reg[k][0][NW-1];
                sg_d_reg[k]   <= sg_c_reg[k];
                lmax_c_reg[k] <= (len_reg[2*k+1] > len_reg[2*k]) ? len_reg[2*k+1]
                                                                  : len_reg[2*k];
            end
            if (lmax_c_reg[0] >= lmax_c_reg[1] && lmax_c_reg[0] >= lmax_c_reg[2]) begin
                lmax_d_reg <= lmax_c_reg[0];
            end else if (lmax_c_reg[1] >= lmax_c_reg[2]) begin
                lmax_d_reg <= lmax_c_reg[1];
            end else begin
                lmax_d_reg <= lmax_c_reg[2];
            end
        end
    end

    always_comb begin
        logic signed [VW-1:0] t;
        vsum = '0;
        for (int k = 0; k < 3; k++) begin
            t = $signed({{(VW-PW){1'b0}}, vp[k]});
            vsum = vsum + (sg_d_reg[k] ? -t : t);
        end
    end

    // stage E: volume sign check; volume magnitude, normals and longest edge registered
    always_ff @(posedge aclk) begin
        if (en) begin
            n_e_reg  <= n_d_reg;
            l_e_reg  <= lmax_d_reg;
            inv_reg  <= vsum[VW-1] || (vsum == '0);
            vabs_reg <= vsum[VMW-1:0];
        end
    end

    always_comb begin
        for (int f = 0; f < 4; f++) begin
            for (int c = 0; c < 3; c++) begin
                out_data[(f*3+c)*NW +: NW] = n_e_reg[f][c];
            end
        end
        out_data[12*NW +: VMW]     = vabs_reg;
        out_data[12*NW+VMW +: LW]  = l_e_reg;
        out_data[12*NW+VMW+LW]     = inv_reg;
    end

endmodule

### hdl/tfsar_queue.sv
`timescale 1ns / 1ps
`include "tet_fast_squared_aspect_ratio_macros.svh"
module tfsar_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    localparam int DEPTH = tfsar_pkg::QUEUE_DEPTH;
    localparam int AWD   = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]   mem_reg [DEPTH];
    logic [AWD-1:0] wr_ptr_reg;
    logic [AWD-1:0] rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic [AWD-1:0] wr_ptr_next;
    logic [AWD-1:0] rd_ptr_next;
    logic [CW-1:0]  cnt_next;
    logic           push;
    logic           pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (cnt_reg != CW'(DEPTH)) || pop;
    assign push      = in_valid && in_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AWD'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AWD'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `TFSAR_ASSERT_NEXT(a_fill_count, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `TFSAR_ASSERT_IMPL(a_full_stall, aclk, aresetn, (cnt_reg == CW'(DEPTH)) && !out_ready, !in_ready)

endmodule

### hdl/tfsar_back.sv
`timescale 1ns / 1ps
`include "tet_fast_squared_aspect_ratio_macros.svh"
// Face norms, denominator and bit-per-stage division.
module tfsar_back #(
    parameter int COORD_BITS     = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [12*(2*COORD_BITS+2)+(3*COORD_BITS+3)+(2*COORD_BITS+2):0] in_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tfsar_pkg::out_item_t  m_item
);

    localparam int C     = COORD_BITS;
    localparam int F     = NORM_FRAC_BITS;
    localparam int QB    = tfsar_pkg::Q_BITS;
    localparam int NW    = 2*C + 2;
    localparam int MAGW  = NW - 1;
    localparam int VMW   = 3*C + 3;
    localparam int LW    = 2*C + 2;
    localparam int QW    = 12*NW + VMW + LW + 1;
    localparam int SW    = 4*C + 4;
    localparam int SSW   = SW + 2*F;
    localparam int RW    = SSW / 2;
    localparam int AREAW = RW + 2;
    localparam int A2W   = 2*AREAW;
    localparam int DENW  = A2W + LW;
    localparam int V2W   = 2*VMW;
    localparam int NUMW  = V2W + QB + 2*F;
    localparam int RMW   = (NUMW > DENW + QB) ? NUMW : DENW + QB;
    localparam int TR    = 3 + RW;
    localparam int LAST  = TR + 6 + QB;

    logic                 en;
    logic [LAST:0]        vld_reg;
    logic [LAST:0]        inv_reg;
    logic signed [NW-1:0] n_reg [4][3];
    logic [MAGW-1:0]      nmag [4][3];
    logic [2*MAGW-1:0]    sq [4][3];
    logic [VMW-1:0]       vabs_reg [TR+2];
    logic [LW-1:0]        l_reg [TR+4];
    logic [SSW-1:0]       op_reg [4][RW+1];
    logic [SSW-1:0]       res_reg [4][RW+1];
    logic [AREAW-1:0]     area_reg;
    logic [A2W-1:0]       a2;
    logic [V2W-1:0]       v2;
    logic [V2W-1:0]       v2_reg [2];
    logic [DENW-1:0]      den;
    logic [RMW-1:0]       num;
    logic [RMW-1:0]       r_reg [QB];
    logic [DENW-1:0]      dd_reg [QB];
    logic [QB-1:0]        q_reg [QB+1];
    logic                 sat_reg [QB+1];

    function automatic logic [2*SSW-1:0] sq_step(
        input logic [SSW-1:0] op,
        input logic [SSW-1:0] res,
        input logic [SSW-1:0] one
    );
        logic [SSW:0] t;
        begin
            t = {1'b0, res} + {1'b0, one};
            if ({1'b0, op} >= t) begin
                return {op - t[SSW-1:0], (res >> 1) + one};
            end
            return {op, res >> 1};
        end
    endfunction

    function automatic logic [RMW+QB-1:0] div_step(
        input logic [RMW-1:0]  r,
        input logic [DENW-1:0] d,
        input logic [QB-1:0]   q,
        input int              sh
    );
        logic [RMW-1:0] ds;
        begin
            ds = RMW'(d) << sh;
            if (r >= ds) begin
                return {r - ds, q | (QB'(1) << sh)};
            end
            return {r, q};
        end
    endfunction

    assign en       = !vld_reg[LAST] || m_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg <= {inv_reg[LAST-1:0], in_data[QW-1]};
            for (int f = 0; f < 4; f++) begin
                for (int c = 0; c < 3; c++) begin
                    n_reg[f][c] <= in_data[(f*3+c)*NW +: NW];
                end
            end
            vabs_reg[0] <= in_data[12*NW +: VMW];
            l_reg[0]    <= in_data[12*NW+VMW +: LW];
            for (int k = 1; k < TR + 2; k++) begin
                vabs_reg[k] <= vabs_reg[k-1];
            end
            for (int k = 1; k < TR + 4; k++) begin
                l_reg[k] <= l_reg[k-1];
            end
        end
    end

    always_comb begin
        for (int f = 0; f < 4; f++) begin
            for (int c = 0; c < 3; c++) begin
                nmag[f][c] = n_reg[f][c][NW-1] ? MAGW'(-n_reg[f][c]) : n_reg[f][c][MAGW-1:0];
            end
        end
    end

    for (genvar f = 0; f < 4; f++) begin : g_face
        for (genvar c = 0; c < 3; c++) begin : g_comp
            tfsar_mul #(.AW(MAGW), .BW(MAGW)) u_sq (
                .aclk (aclk),
                .en   (en),
                .a    (nmag[f][c]),
                .b    (nmag[f][c]),
                .p    (sq[f][c])
            );
        end
    end

    // digit-by-digit square root, one result bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int f = 0; f < 4; f++) begin
                op_reg[f][0]  <= SSW'(SW'(sq[f][0]) + SW'(sq[f][1]) + SW'(sq[f][2])) << (2*F);
                res_reg[f][0] <= '0;
                for (int k = 0; k < RW; k++) begin
                    {op_reg[f][k+1], res_reg[f][k+1]} <=
                        sq_step(op_reg[f][k], res_reg[f][k], SSW'(1) << (2*(RW-1-k)));
                end
            end
            area_reg <= AREAW'(res_reg[0][RW][RW-1:0]) + AREAW'(res_reg[1][RW][RW-1:0])
                      + AREAW'(res_reg[2][RW][RW-1:0]) + AREAW'(res_reg[3][RW][RW-1:0]);
        end
    end

    tfsar_mul #(.AW(AREAW), .BW(AREAW)) u_area_sq (
        .aclk (aclk),
        .en   (en),
        .a    (area_reg),
        .b    (area_reg),
        .p    (a2)
    );

    tfsar_mul #(.AW(VMW), .BW(VMW)) u_vol_sq (
        .aclk (aclk),
        .en   (en),
        .a    (vabs_reg[TR+1]),
        .b    (vabs_reg[TR+1]),
        .p    (v2)
    );

    tfsar_mul #(.AW(LW), .BW(A2W)) u_den (
        .aclk (aclk),
        .en   (en),
        .a    (l_reg[TR+3]),
        .b    (a2),
        .p    (den)
    );

    assign num = RMW'({v2_reg[1], {(QB+2*F){1'b0}}});

    // restoring division, one quotient bit per stage, saturation decided up front
    always_ff @(posedge aclk) begin
        if (en) begin
            v2_reg[0]  <= v2;
            v2_reg[1]  <= v2_reg[0];
            r_reg[0]   <= num;
            dd_reg[0]  <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= num >= (RMW'(den) << QB);
            for (int j = 0; j < QB - 1; j++) begin
                {r_reg[j+1], q_reg[j+1]} <= div_step(r_reg[j], dd_reg[j], q_reg[j], QB-1-j);
                dd_reg[j+1] <= dd_reg[j];
            end
            q_reg[QB] <= q_reg[QB-1] | QB'(r_reg[QB-1] >= RMW'(dd_reg[QB-1]));
            for (int j = 0; j < QB; j++) begin
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    assign m_valid          = vld_reg[LAST];
    assign m_item.inverted  = inv_reg[LAST];
    assign m_item.quality   = inv_reg[LAST] ? '0 : (sat_reg[QB] ? '1 : q_reg[QB]);

    `TFSAR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !en, vld_reg == $past(vld_reg))

endmodule

### hdl/tet_fast_squared_aspect_ratio.sv
`timescale 1ns / 1ps
// Accepts one item per cycle while the output is not stalled; the square root (one bit per
// stage) and the 32-stage divider are fully pipelined, so neither loop holds the input.
// A four-entry queue separates the geometry front end from the norm/division back end.
// Reset: aresetn, synchronous active low, clears all valid state and queue pointers.
module tet_fast_squared_aspect_ratio #(
    parameter int COORD_BITS     = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tfsar_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tfsar_pkg::out_item_t  m_item
);

    localparam int QW = 12*(2*COORD_BITS+2) + (3*COORD_BITS+3) + (2*COORD_BITS+2) + 1;

    logic          f_valid;
    logic          f_ready;
    logic [QW-1:0] f_data;
    logic          b_valid;
    logic          b_ready;
    logic [QW-1:0] b_data;

    tfsar_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    tfsar_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    tfsar_back #(
        .COORD_BITS     (COORD_BITS),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_data  (b_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

### dv/tb_tet_fast_squared_aspect_ratio.sv
`timescale 1ns / 1ps
module tb_tet_fast_squared_aspect_ratio;

    localparam int COORD_BITS     = 16;
    localparam int NORM_FRAC_BITS = 8;
    localparam int LATENCY        = 2*COORD_BITS + NORM_FRAC_BITS + 49;
    localparam int N_RANDOM       = 450;
    localparam int IDLE_LIMIT     = 20000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    tfsar_pkg::in_item_t  s_item;
    logic                 m_valid;
    logic                 m_ready;
    tfsar_pkg::out_item_t m_item;

    tet_fast_squared_aspect_ratio #(
        .COORD_BITS(COORD_BITS),
        .NORM_FRAC_BITS(NORM_FRAC_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    tfsar_pkg::in_item_t  tet_queue[$];
    tfsar_pkg::out_item_t quality_expected[$];
    int        n_mismatch = 0;
    int        n_checked = 0;
    int        n_inverted = 0;
    int        n_saturated = 0;
    int        idle_cycles = 0;
    bit        feeding_done = 0;
    bit        hold_off = 0;
    bit        in_taken = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [127:0] isqrt_fixed(logic [255:0] s);
        logic [127:0] r;
        logic [255:0] cand;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            cand = {128'd0, r | (128'd1 << i)};
            if (cand * cand <= s) r = r | (128'd1 << i);
        end
        return r;
    endfunction

    function automatic logic [127:0] face_norm(longint x, longint y, longint z);
        logic signed [255:0] sx, sy, sz;
        logic [255:0] s;
        sx = x; sy = y; sz = z;
        s = sx*sx + sy*sy + sz*sz;
        return isqrt_fixed(s << (2*NORM_FRAC_BITS));
    endfunction

    function automatic longint coord(logic [tfsar_pkg::FIELD_W-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return longint'(t);
    endfunction

    function automatic tfsar_pkg::out_item_t predict_quality(tfsar_pkg::in_item_t t);
        longint p[4][3];
        longint ab[3], ac[3], ad[3], bc[3], cd[3], db[3];
        longint n0[3], n1[3], n2[3], n3[3];
        longint l, e;
        logic signed [255:0] vol;
        logic [255:0] area, num, den, prod;
        logic [31:0] q, c;
        tfsar_pkg::out_item_t r;
        p[0] = '{coord(t.ax), coord(t.ay), coord(t.az)};
        p[1] = '{coord(t.bx), coord(t.by), coord(t.bz)};
        p[2] = '{coord(t.cx), coord(t.cy), coord(t.cz)};
        p[3] = '{coord(t.dx), coord(t.dy), coord(t.dz)};
        for (int i = 0; i < 3; i++) begin
            ab[i] = p[1][i] - p[0][i];
            ac[i] = p[2][i] - p[0][i];
            ad[i] = p[3][i] - p[0][i];
            db[i] = p[1][i] - p[3][i];
            bc[i] = p[2][i] - p[1][i];
            cd[i] = p[3][i] - p[2][i];
        end
        n0 = '{ac[1]*ad[2]-ac[2]*ad[1], ac[2]*ad[0]-ac[0]*ad[2], ac[0]*ad[1]-ac[1]*ad[0]};
        n1 = '{ad[1]*ab[2]-ad[2]*ab[1], ad[2]*ab[0]-ad[0]*ab[2], ad[0]*ab[1]-ad[1]*ab[0]};
        n2 = '{ab[1]*ac[2]-ab[2]*ac[1], ab[2]*ac[0]-ab[0]*ac[2], ab[0]*ac[1]-ab[1]*ac[0]};
        n3 = '{bc[1]*cd[2]-bc[2]*cd[1], bc[2]*cd[0]-bc[0]*cd[2], bc[0]*cd[1]-bc[1]*cd[0]};
        vol = 256'(signed'(ab[0])) * 256'(signed'(n0[0]))
            + 256'(signed'(ac[0])) * 256'(signed'(n1[0]))
            + 256'(signed'(ad[0])) * 256'(signed'(n2[0]));
        r = '0;
        if (vol <= 0) begin
            r.inverted = 1'b1;
            return r;
        end
        area = 256'(face_norm(n0[0], n0[1], n0[2])) + 256'(face_norm(n1[0], n1[1], n1[2]))
             + 256'(face_norm(n2[0], n2[1], n2[2])) + 256'(face_norm(n3[0], n3[1], n3[2]));
        l = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
        e = ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2]; if (e > l) l = e;
        e = ad[0]*ad[0] + ad[1]*ad[1] + ad[2]*ad[2]; if (e > l) l = e;
        e = bc[0]*bc[0] + bc[1]*bc[1] + bc[2]*bc[2]; if (e > l) l = e;
        e = cd[0]*cd[0] + cd[1]*cd[1] + cd[2]*cd[2]; if (e > l) l = e;
        e = db[0]*db[0] + db[1]*db[1] + db[2]*db[2]; if (e > l) l = e;
        num = (256'(vol) * 256'(vol)) << (32 + 2*NORM_FRAC_BITS);
        den = area * area * 256'(l);
        q = '0;
        for (int i = 31; i >= 0; i--) begin
            c = q | (32'd1 << i);
            prod = den * 256'(c);
            if (prod <= num) q = c;
        end
        r.quality = q;
        return r;
    endfunction

    function automatic logic [15:0] rnd_coord(int span);
        if (span >= 16) return 16'($urandom);
        return 16'($urandom_range(0, (1 << span) - 1) - (1 << (span - 1)));
    endfunction

    task automatic add_tet(logic [15:0] c[12]);
        tfsar_pkg::in_item_t t;
        t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
        tet_queue.push_back(t);
    endtask

    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item  <= '0;
        end else if (s_valid && !in_taken) begin
        end else if (tet_queue.size() > 0 && $urandom_range(0, 9) < 7) begin
            s_valid <= 1'b1;
            s_item  <= tet_queue.pop_front();
        end else begin
            s_valid <= 1'b0;
            if (tet_queue.size() > 0 && $urandom_range(0, 29) == 0)
                repeat ($urandom_range(5, 40)) @(negedge aclk);
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(5, 60)) @(negedge aclk);
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            quality_expected.push_back(predict_quality(s_item));
    end

    always @(posedge aclk) begin
        tfsar_pkg::out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (quality_expected.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: quality=%h inverted=%b",
                             m_item.quality, m_item.inverted);
            end else begin
                exp_item = quality_expected.pop_front();
                n_checked++;
                if (exp_item.inverted) n_inverted++;
                if (exp_item.quality == '1) n_saturated++;
                if (m_item.quality !== exp_item.quality || m_item.inverted !== exp_item.inverted) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: expected quality=%h inverted=%b, got %h %b",
                                 n_checked, exp_item.quality, exp_item.inverted,
                                 m_item.quality, m_item.inverted);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("tet_fast_squared_aspect_ratio: mismatch");
                $finish;
            end
        end
    end

    // receiver stall long enough to back up the pipeline
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (3*LATENCY) @(negedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        logic [15:0] c[12];
        int span;
        aresetn = 1'b0;

        // right-handed unit tetrahedron, its mirror, degenerate and extreme shapes
        add_tet('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1});
        add_tet('{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1});
        add_tet('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_tet('{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3});
        add_tet('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff});
        add_tet('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff});
        add_tet('{16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h0, 16'h0,
                  16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff});
        // sliver: near-zero volume, long edges
        add_tet('{0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff, 0, 16'h3fff, 16'h3fff, 1});
        // regular-ish tetrahedron (high quality), then its inverted mirror
        add_tet('{1000, 1000, 1000, 16'hfc18, 16'hfc18, 1000,
                  16'hfc18, 1000, 16'hfc18, 1000, 16'hfc18, 16'hfc18});
        add_tet('{1000, 1000, 1000, 16'hfc18, 1000, 16'hfc18,
                  16'hfc18, 16'hfc18, 1000, 1000, 16'hfc18, 16'hfc18});
        add_tet('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000});
        add_tet('{5, 5, 5, 6, 5, 5, 5, 6, 5, 5, 5, 6});

        for (int n = 0; n < N_RANDOM; n++) begin
            span = $urandom_range(0, 3) == 0 ? 16 : $urandom_range(2, 15);
            for (int k = 0; k < 12; k++) c[k] = rnd_coord(span);
            add_tet(c);
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (tet_queue.size() == 0 && !s_valid);
        wait (quality_expected.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("checked %0d tetrahedra (%0d inverted or flat, %0d saturated)",
                 n_checked, n_inverted, n_saturated);
        $display("including extreme coordinates and a long receiver stall");
        if (n_mismatch == 0 && quality_expected.size() == 0)
            $display("tet_fast_squared_aspect_ratio: match");
        else
            $display("tet_fast_squared_aspect_ratio: mismatch");
        $finish;
    end

endmodule
